// ===== design/ksl_pkg.sv =====
// Package: shared constants and types for the keyed score list engine.
`timescale 1ns / 1ps
package ksl_pkg;
    localparam int CAPACITY = 32;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KEY_W = 32;
    localparam int SCORE_W = 16;
    localparam int REC_W = KEY_W + SCORE_W;

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK = 3'd1;
    localparam logic [2:0] CMD_FIND = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_UPDATE = 3'd4;
    localparam logic [2:0] CMD_SORT = 3'd5;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
endpackage

// ===== design/ksl_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ksl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/keyed_score_list_engine.sv =====
// Top level: ordered record list with search, shift and insertion sort over one RAM.
// Insert back writes the RAM on accept; find/update search the entries in order; insert
//   front and delete walk the list, one read and one write per entry.
// Sort: insertion sort, one RAM access pair per step.
// One word in flight at a time; the result register frees the input while it waits.
// Reset (rst_n low, async): list empty; RAM contents undefined, never read unwritten.
`timescale 1ns / 1ps
module keyed_score_list_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      cmd,
    input  logic signed [ksl_pkg::KEY_W-1:0] key,
    input  logic [ksl_pkg::SCORE_W-1:0]     score,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic signed [ksl_pkg::KEY_W-1:0] found_key,
    output logic [ksl_pkg::SCORE_W-1:0]     found_score,
    output logic [5:0]                      entry_count
);
    import ksl_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SRD   = 9'b000000010, // search: read issued
        S_SCMP  = 9'b000000100, // search: compare data
        S_SHRD  = 9'b000001000, // shift read issued
        S_SHWR  = 9'b000010000, // shift write
        S_ORD   = 9'b000100000, // sort outer: read element i
        S_OCAP  = 9'b001000000, // sort: capture element, read j-1
        S_ICMP  = 9'b010000000, // sort inner compare / move
        S_RESP  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0]         cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [SCORE_W-1:0] score_reg, score_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   i_reg, i_next;   // walk / outer index
    logic [CNT_W-1:0]   j_reg, j_next;   // inner index
    logic [REC_W-1:0]   hold_reg, hold_next; // record held by the sort
    logic               ov_reg, ov_next;
    logic [1:0]         st_reg, st_next;
    logic [KEY_W-1:0]   fk_reg, fk_next;
    logic [SCORE_W-1:0] fs_reg, fs_next;
    // result word waiting on the output side
    logic [1:0]         out_st_reg, out_st_next;
    logic [KEY_W-1:0]   out_fk_reg, out_fk_next;
    logic [SCORE_W-1:0] out_fs_reg, out_fs_next;
    logic [5:0]         out_cnt_reg, out_cnt_next;

    logic               we;
    logic [IDX_W-1:0]   waddr, raddr;
    logic [REC_W-1:0]   wdata, rdata;

    ksl_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = ov_reg;
    assign status      = out_st_reg;
    assign found_key   = out_fk_reg;
    assign found_score = out_fs_reg;
    assign entry_count = out_cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        key_next = key_reg;
        score_next = score_reg;
        count_next = count_reg;
        i_next = i_reg;
        j_next = j_reg;
        hold_next = hold_reg;
        ov_next = ov_reg;
        st_next = st_reg;
        fk_next = fk_reg;
        fs_next = fs_reg;
        out_st_next = out_st_reg;
        out_fk_next = out_fk_reg;
        out_fs_next = out_fs_reg;
        out_cnt_next = out_cnt_reg;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd_next = cmd;
                    key_next = key;
                    score_next = score;
                    st_next = ST_DONE;
                    fk_next = '0;
                    fs_next = '0;
                    i_next = '0;
                    state_next = S_RESP;
                    case (cmd) inside
                        CMD_INS_FRONT, CMD_INS_BACK:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                st_next = ST_FULL;
                            end
                            else if (cmd == CMD_INS_BACK || count_reg == '0)
                            begin
                                we = 1'b1;
                                waddr = IDX_W'(count_reg);
                                wdata = {key, score};
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                // shift up from the tail
                                i_next = count_reg;
                                state_next = S_SHRD;
                            end
                        end
                        CMD_FIND, CMD_DELETE, CMD_UPDATE:
                        begin
                            state_next = S_SRD;
                        end
                        CMD_SORT:
                        begin
                            i_next = CNT_W'(1);
                            state_next = S_ORD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SRD:
            begin
                if (i_reg >= count_reg)
                begin
                    st_next = ST_MISS;
                    state_next = S_RESP;
                end
                else
                begin
                    raddr = IDX_W'(i_reg);
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (rdata[REC_W-1:SCORE_W] == key_reg)
                begin
                    fk_next = rdata[REC_W-1:SCORE_W];
                    fs_next = rdata[SCORE_W-1:0];
                    state_next = S_RESP;
                    if (cmd_reg == CMD_UPDATE)
                    begin
                        we = 1'b1;
                        waddr = IDX_W'(i_reg);
                        wdata = {key_reg, score_reg};
                        fs_next = score_reg;
                    end
                    else if (cmd_reg == CMD_DELETE)
                    begin
                        // close the gap: pull entries down from i+1
                        count_next = count_reg - 1'b1;
                        state_next = S_SHRD;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_SHRD:
            begin
                if (cmd_reg == CMD_DELETE)
                begin
                    if (i_reg >= count_reg)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        raddr = IDX_W'(i_reg + 1'b1);
                        state_next = S_SHWR;
                    end
                end
                else if (i_reg == '0)
                begin
                    we = 1'b1;
                    waddr = '0;
                    wdata = {key_reg, score_reg};
                    count_next = count_reg + 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    raddr = IDX_W'(i_reg - 1'b1);
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                we = 1'b1;
                waddr = IDX_W'(i_reg);
                wdata = rdata;
                i_next = (cmd_reg == CMD_DELETE) ? i_reg + 1'b1 : i_reg - 1'b1;
                state_next = S_SHRD;
            end
            S_ORD:
            begin
                if (i_reg >= count_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    raddr = IDX_W'(i_reg);
                    j_next = i_reg;
                    state_next = S_OCAP;
                end
            end
            S_OCAP:
            begin
                // rdata holds element i; j = i > 0 always here
                hold_next = rdata;
                raddr = IDX_W'(j_reg - 1'b1);
                state_next = S_ICMP;
            end
            S_ICMP:
            begin
                // rdata holds element j-1 while j > 0
                if (j_reg != '0 && rdata[SCORE_W-1:0] > hold_reg[SCORE_W-1:0])
                begin
                    // move the larger record up one slot, read the next lower one
                    we = 1'b1;
                    waddr = IDX_W'(j_reg);
                    wdata = rdata;
                    j_next = j_reg - 1'b1;
                    raddr = (j_reg == CNT_W'(1)) ? '0 : IDX_W'(j_reg - 2'd2);
                end
                else
                begin
                    // drop the held record into its slot
                    we = 1'b1;
                    waddr = IDX_W'(j_reg);
                    wdata = hold_reg;
                    i_next = i_reg + 1'b1;
                    state_next = S_ORD;
                end
            end
            S_RESP:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    out_st_next = st_reg;
                    out_fk_next = fk_reg;
                    out_fs_next = fs_reg;
                    out_cnt_next = 6'(count_reg);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        score_reg <= score_next;
        i_reg <= i_next;
        j_reg <= j_next;
        hold_reg <= hold_next;
        st_reg <= st_next;
        fk_reg <= fk_next;
        fs_reg <= fs_next;
        out_st_reg <= out_st_next;
        out_fk_reg <= out_fk_next;
        out_fs_reg <= out_fs_next;
        out_cnt_reg <= out_cnt_next;
    end

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY)) else $error("count beyond capacity");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (CNT_W'(waddr) <= count_reg)) else $error("write past list end");
endmodule
